// File: rtl/raa_pkg.sv
// ----------------------------------------------------------------------------
// raa_pkg: shared types and constants
// Word types, opcodes, status codes and controller/datapath command signals.
// ----------------------------------------------------------------------------
package raa_pkg;

   localparam int DEF_DATA_WIDTH = 32;

   localparam logic [2:0] OP_LOAD = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] operand_num;
      logic signed [31:0] operand_den;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_num;
      logic [30:0]        result_den;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic load;    // capture operands, form magnitudes
      logic prod1;   // first products
      logic prod2;   // second products
      logic comb;    // combine into rn/rd
      logic gstep;   // one binary gcd step (halve or subtract)
      logic dstep;   // one division bit step (both quotients)
      logic commit;  // check range, update accumulator
   } cmd_type;

   typedef struct packed {
      logic skip;    // no arithmetic: error or unused opcode
      logic gdone;   // gcd finished
      logic ddone;   // division finished
   } sts_type;

endpackage

// File: rtl/raa_datapath.sv
// ----------------------------------------------------------------------------
// raa_datapath: rational arithmetic datapath
// Products, signed sum, binary gcd and restoring division by the gcd.
// ----------------------------------------------------------------------------
module raa_datapath import raa_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  req_type req,
   input  cmd_type cmd,
   output sts_type sts,
   output rsp_type rsp
);
   localparam int W  = DATA_WIDTH;
   localparam int W2 = 2 * DATA_WIDTH;
   localparam int CW = $clog2(W2 + 1);

   logic [W-1:0]  acc_num_ff, acc_den_ff;
   logic [2:0]    op_ff;
   logic          sc_ff, sa_ff, sr_ff, skip_ff;
   logic [1:0]    status_ff;
   logic [W-1:0]  mc_ff, md_ff, ma_ff, mb_ff;
   logic [W2-1:0] p1_ff, p2_ff, rn_ff, rd_ff;
   // binary gcd: halve even terms, count common twos, subtract odd ones
   logic [W2-1:0] ga_ff, gb_ff;
   logic [CW-1:0] gk_ff;
   // division of both terms by the gcd, one quotient bit a cycle
   logic [W2-1:0] g_ff, qn_ff, qd_ff, rmn_ff, rmd_ff;
   logic [CW-1:0] dc_ff;

   logic [W-1:0]  rn_w, rd_w, an_w, sgn_w;
   logic          sc_w, sd_w, sa_w, zero_w;
   logic [W-1:0]  mc_w, md_w, ma_w;

   assign sgn_w  = {1'b1, {(W-1){1'b0}}};
   assign rn_w   = req.operand_num[W-1:0];
   assign rd_w   = req.operand_den[W-1:0];
   assign sc_w   = rn_w[W-1];
   assign sd_w   = rd_w[W-1];
   assign sa_w   = acc_num_ff[W-1];
   assign mc_w   = sc_w ? (~rn_w + 1'b1) : rn_w;
   assign md_w   = sd_w ? (~rd_w + 1'b1) : rd_w;
   assign ma_w   = sa_w ? (~acc_num_ff + 1'b1) : acc_num_ff;
   assign zero_w = (md_w == '0) || (req.opcode == OP_DIV && mc_w == '0);
   assign an_w   = ~qn_ff[W-1:0] + 1'b1;

   logic          s2_w, cs_w, ovf_w, gdone_w, bn_w, bd_w;
   logic [W2-1:0] cn_w, cd_w, na_w, nb_w, g_w, rem_n, rem_d;
   logic [CW-1:0] nk_w;
   logic [W2:0]   sn_w, sdv_w;

   // sign and magnitude of the combined numerator
   always_comb begin
      s2_w = (op_ff == OP_SUB) ? ~sc_ff : sc_ff;
      cd_w = rd_ff;
      if (op_ff == OP_ADD || op_ff == OP_SUB) begin
         if (sa_ff == s2_w) begin
            cn_w = p1_ff + p2_ff; cs_w = sa_ff;
         end else if (p1_ff >= p2_ff) begin
            cn_w = p1_ff - p2_ff; cs_w = sa_ff;
         end else begin
            cn_w = p2_ff - p1_ff; cs_w = s2_w;
         end
      end else begin
         cn_w = p1_ff;
         cs_w = (op_ff == OP_LOAD) ? sc_ff : (sa_ff ^ sc_ff);
         if (op_ff != OP_MUL) cd_w = p2_ff;
      end
   end

   always_comb begin
      na_w = ga_ff;
      nb_w = gb_ff;
      nk_w = gk_ff;
      if (!ga_ff[0] && !gb_ff[0]) begin
         na_w = ga_ff >> 1;
         nb_w = gb_ff >> 1;
         nk_w = gk_ff + 1'b1;
      end else if (!ga_ff[0]) begin
         na_w = ga_ff >> 1;
      end else if (!gb_ff[0]) begin
         nb_w = gb_ff >> 1;
      end else if (ga_ff > gb_ff) begin
         na_w = (ga_ff - gb_ff) >> 1;
      end else begin
         nb_w = (gb_ff - ga_ff) >> 1;
      end
   end

   // a zero numerator ends at once with the denominator as divisor
   assign gdone_w = (ga_ff == '0) || (ga_ff == gb_ff);
   assign g_w     = ((ga_ff == '0) ? gb_ff : ga_ff) << gk_ff;

   assign sn_w  = {rmn_ff, qn_ff[W2-1]};
   assign sdv_w = {rmd_ff, qd_ff[W2-1]};
   assign bn_w  = sn_w >= {1'b0, g_ff};
   assign bd_w  = sdv_w >= {1'b0, g_ff};
   assign rem_n = bn_w ? W2'(sn_w - {1'b0, g_ff}) : sn_w[W2-1:0];
   assign rem_d = bd_w ? W2'(sdv_w - {1'b0, g_ff}) : sdv_w[W2-1:0];

   assign ovf_w = (qd_ff > {{W{1'b0}}, sgn_w - 1'b1}) ||
                  (qn_ff > (sr_ff ? {{W{1'b0}}, sgn_w} : {{W{1'b0}}, sgn_w - 1'b1}));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_num_ff <= '0;
         acc_den_ff <= {{(W-1){1'b0}}, 1'b1};
         status_ff  <= ST_OK;
         dc_ff      <= '0;
      end else begin
         if (cmd.load) begin
            op_ff <= req.opcode;
            sc_ff <= sc_w ^ sd_w;
            sa_ff <= sa_w;
            mc_ff <= mc_w;
            md_ff <= md_w;
            ma_ff <= ma_w;
            mb_ff <= (acc_den_ff == '0) ? {{(W-1){1'b0}}, 1'b1} : acc_den_ff;
            skip_ff   <= (req.opcode > OP_DIV) || zero_w;
            status_ff <= (req.opcode <= OP_DIV && zero_w) ? ST_ZERO : ST_OK;
         end
         if (cmd.prod1) begin
            unique case (op_ff)
               OP_LOAD: p1_ff <= {{W{1'b0}}, mc_ff};
               OP_DIV:  p1_ff <= ma_ff * md_ff;
               default: p1_ff <= ma_ff * ((op_ff == OP_MUL) ? mc_ff : md_ff);
            endcase
         end
         if (cmd.prod2) begin
            unique case (op_ff)
               OP_LOAD: p2_ff <= {{W{1'b0}}, md_ff};
               OP_DIV:  p2_ff <= mb_ff * mc_ff;
               OP_MUL:  p2_ff <= mb_ff * md_ff;
               default: p2_ff <= mc_ff * mb_ff;
            endcase
            rd_ff <= mb_ff * md_ff;
         end
         if (cmd.comb) begin
            rn_ff <= cn_w;
            rd_ff <= cd_w;
            sr_ff <= cs_w;
            ga_ff <= cn_w;
            gb_ff <= cd_w;
            gk_ff <= '0;
         end
         if (cmd.gstep && !gdone_w) begin
            ga_ff <= na_w;
            gb_ff <= nb_w;
            gk_ff <= nk_w;
         end
         if (cmd.dstep) begin
            if (dc_ff == '0) begin
               g_ff   <= g_w;
               qn_ff  <= rn_ff;
               qd_ff  <= rd_ff;
               rmn_ff <= '0;
               rmd_ff <= '0;
               dc_ff  <= CW'(W2);
            end else begin
               rmn_ff <= rem_n;
               rmd_ff <= rem_d;
               qn_ff  <= {qn_ff[W2-2:0], bn_w};
               qd_ff  <= {qd_ff[W2-2:0], bd_w};
               dc_ff  <= dc_ff - 1'b1;
            end
         end
         if (cmd.commit) begin
            dc_ff <= '0;
            if (!skip_ff) begin
               if (ovf_w) status_ff <= ST_OVF;
               else begin
                  acc_num_ff <= sr_ff ? an_w : qn_ff[W-1:0];
                  acc_den_ff <= qd_ff[W-1:0];
               end
            end
         end
      end
   end

   assign sts.skip  = skip_ff;
   assign sts.gdone = gdone_w;
   assign sts.ddone = dc_ff == CW'(1);

   always_comb begin
      rsp.result_num = 32'(acc_num_ff);
      rsp.result_den = 31'(acc_den_ff);
      rsp.status     = status_ff;
   end
endmodule

// File: rtl/raa_control.sv
// ----------------------------------------------------------------------------
// raa_control: sequencing controller
// Steps the datapath through products, gcd, division and commit per word.
// ----------------------------------------------------------------------------
module raa_control import raa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output cmd_type cmd
);
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_P1   = 8'b0000_0010,
      S_P2   = 8'b0000_0100,
      S_COMB = 8'b0000_1000,
      S_GCD  = 8'b0001_0000,
      S_DIV  = 8'b0010_0000,
      S_CMT  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_OUT;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: if (req_valid) begin cmd.load = 1'b1; state_in = S_P1; end
         S_P1:   begin
            cmd.prod1 = 1'b1;
            state_in = sts.skip ? S_CMT : S_P2;
         end
         S_P2:   begin cmd.prod2 = 1'b1; state_in = S_COMB; end
         S_COMB: begin cmd.comb = 1'b1; state_in = S_GCD; end
         S_GCD:  begin
            cmd.gstep = 1'b1;
            if (sts.gdone) state_in = S_DIV;
         end
         S_DIV:  begin
            cmd.dstep = 1'b1;
            if (sts.ddone) state_in = S_CMT;
         end
         S_CMT:  begin cmd.commit = 1'b1; state_in = S_OUT; end
         S_OUT:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end
endmodule

// File: rtl/rational_accumulator_alu.sv
// ----------------------------------------------------------------------------
// rational_accumulator_alu: rational accumulator with gcd reduction
// Each word runs through load, products, combine, binary gcd steps, division by
// the gcd and commit to rsp_valid; a word with an error or unused opcode goes
// from the first products to commit. One word at a time: the next word is taken
// at the edge after the response leaves. Division takes 64 steps on 64-bit terms.
// Synchronous reset sets the accumulator to 0/1 with no word pending.
// ----------------------------------------------------------------------------
module rational_accumulator_alu import raa_pkg::*; #(
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   cmd_type cmd;
   sts_type sts;

   raa_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .sts, .cmd
   );

   raa_datapath #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
      .clock, .reset, .req(req_data), .cmd, .sts, .rsp(rsp_data)
   );
endmodule
